[src/mwm_pkg.sv]
package mwm_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int LANES         = 4;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;

    // four-way sum of IN_W operands
    localparam int SUM_W = IN_W + 2;
    localparam int MAG_W = SUM_W;
    // quotient never exceeds ONE
    localparam int Q_W   = FRACTION_BITS + 1;
    localparam int DIV_W = (MAG_W > Q_W) ? MAG_W : Q_W;
    localparam int SQ_W  = 2 * Q_W;
    localparam int RES_W = SQ_W - FRACTION_BITS;
    localparam int CMP_W = ((RES_W > OUT_W) ? RES_W : OUT_W) + 1;

    localparam logic [DIV_W-1:0] ONE_DIV     = DIV_W'(1) << FRACTION_BITS;
    localparam logic [CMP_W-1:0] SAT_POS     = CMP_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic [CMP_W-1:0] SAT_NEG_MAG = CMP_W'(2 ** (OUT_W - 1));

    // lane order matches the result fields
    localparam int LANE_FL = 0;
    localparam int LANE_FR = 1;
    localparam int LANE_RL = 2;
    localparam int LANE_RR = 3;

    typedef struct packed {
        logic                          valid;
        logic [LANES-1:0]              neg;
        logic [DIV_W-1:0]              div;
        logic [LANES-1:0][DIV_W-1:0]   rem;
        logic [LANES-1:0][Q_W-1:0]     low;
    } t_div_item;

    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [RES_W-1:0] mag);
        logic [CMP_W-1:0] m;
        logic [OUT_W-1:0] r;
        m = CMP_W'(mag);
        if (!neg) begin
            r = (m > SAT_POS) ? OUT_W'(SAT_POS) : OUT_W'(m);
        end else begin
            r = (m > SAT_NEG_MAG) ? OUT_W'(SAT_NEG_MAG) : OUT_W'(CMP_W'(0) - m);
        end
        return r;
    endfunction

endpackage

[src/mwm_if.sv]
interface mwm_axes_if import mwm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] right_x;
    logic signed [IN_W-1:0] right_y;
    logic signed [IN_W-1:0] left_x;
    logic signed [IN_W-1:0] trigger_axis;

    modport source (output valid, right_x, right_y, left_x, trigger_axis, input ready);
    modport sink   (input valid, right_x, right_y, left_x, trigger_axis, output ready);
endinterface

interface mwm_wheels_if import mwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] front_left_drive;
    logic signed [OUT_W-1:0] front_right_drive;
    logic signed [OUT_W-1:0] rear_left_drive;
    logic signed [OUT_W-1:0] rear_right_drive;

    modport source (output valid, front_left_drive, front_right_drive, rear_left_drive,
                    rear_right_drive, input ready);
    modport sink   (input valid, front_left_drive, front_right_drive, rear_left_drive,
                    rear_right_drive, output ready);
endinterface

[src/mwm_div_stage.sv]
// one restoring-division step for all four lanes, registered
module mwm_div_stage import mwm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_item i_item,
    output t_div_item o_item
);

    t_div_item                 r_item;
    t_div_item                 n_item;
    logic [LANES-1:0][DIV_W:0] w_trial;
    logic [LANES-1:0]          w_ge;

    always_comb begin
        n_item = i_item;
        for (int l = 0; l < LANES; l++) begin
            w_trial[l] = {i_item.rem[l], i_item.low[l][Q_W-1]};
            w_ge[l]    = w_trial[l] >= {1'b0, i_item.div};
            n_item.rem[l] = w_ge[l] ? DIV_W'(w_trial[l] - {1'b0, i_item.div})
                                    : DIV_W'(w_trial[l]);
            n_item.low[l] = {i_item.low[l][Q_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

[src/mecanum_wheel_mixer_top.sv]
// Mecanum wheel mixer: four stick axes in, four signed-square wheel commands out.
// Registers in order: sums, sign and magnitude, divider load, division stages, square, output.
// Throughput: one beat per cycle while the pipe advances; one quotient bit per division stage, all lanes in step.
// The whole pipe holds while a finished result waits and the sink is not ready.
// Reset (synchronous, active low) clears the valid bits only; no item survives it.
module mecanum_wheel_mixer_top import mwm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mwm_axes_if.sink      i_axes,
    mwm_wheels_if.source  o_wheels
);

    // output register, declared here as the advance depends on it
    logic [LANES-1:0][OUT_W-1:0] r_out;
    logic                        r_out_valid;

    // global advance: an empty output slot or a taken result moves every stage
    logic w_en;
    assign w_en         = !r_out_valid || o_wheels.ready;
    assign i_axes.ready = w_en;

    // stage 1: the four wheel sums, exact
    logic signed [SUM_W-1:0]   w_rx, w_ry, w_lx, w_t;
    logic [LANES-1:0][SUM_W-1:0] n_s1_sum;
    logic [LANES-1:0][SUM_W-1:0] r_s1_sum;
    logic                        r_s1_valid;

    assign w_rx = SUM_W'(i_axes.right_x);
    assign w_ry = SUM_W'(i_axes.right_y);
    assign w_lx = SUM_W'(i_axes.left_x);
    assign w_t  = SUM_W'(i_axes.trigger_axis);

    always_comb begin
        n_s1_sum[LANE_FR] = w_rx + w_ry + w_lx + w_t;
        n_s1_sum[LANE_FL] = w_rx - w_ry + w_lx - w_t;
        n_s1_sum[LANE_RR] = w_ry + w_lx + w_t - w_rx;
        n_s1_sum[LANE_RL] = w_lx - w_rx - w_ry - w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_axes.valid;
            r_s1_sum   <= n_s1_sum;
        end
    end

    // stage 2: sign and magnitude (full negative sum still fits unsigned)
    logic [LANES-1:0][MAG_W-1:0] r_s2_mag;
    logic [LANES-1:0]            r_s2_neg;
    logic                        r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
            for (int l = 0; l < LANES; l++) begin
                r_s2_neg[l] <= r_s1_sum[l][SUM_W-1];
                r_s2_mag[l] <= r_s1_sum[l][SUM_W-1] ? (SUM_W'(0) - r_s1_sum[l])
                                                    : r_s1_sum[l];
            end
        end
    end

    // stage 3: largest magnitude, divisor choice, divider load.
    // Without scaling the divisor is ONE, so (|v| << F) / ONE gives |v| back unchanged.
    logic [MAG_W-1:0]  w_max01, w_max23, w_max;
    logic [DIV_W-1:0]  w_max_d;
    t_div_item         n_s3_item;
    t_div_item         r_s3_item;

    always_comb begin
        w_max01 = (r_s2_mag[1] > r_s2_mag[0]) ? r_s2_mag[1] : r_s2_mag[0];
        w_max23 = (r_s2_mag[3] > r_s2_mag[2]) ? r_s2_mag[3] : r_s2_mag[2];
        w_max   = (w_max23 > w_max01) ? w_max23 : w_max01;
        w_max_d = DIV_W'(w_max);

        n_s3_item.valid = r_s2_valid;
        n_s3_item.neg   = r_s2_neg;
        n_s3_item.div   = (w_max_d > ONE_DIV) ? w_max_d : ONE_DIV;
        for (int l = 0; l < LANES; l++) begin
            // dividend |v| << F: top part preloads the remainder, bit 0 leads the rest
            n_s3_item.rem[l] = DIV_W'(r_s2_mag[l] >> 1);
            n_s3_item.low[l] = {r_s2_mag[l][0], (Q_W - 1)'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_item.valid <= 1'b0;
        end else if (w_en) begin
            r_s3_item <= n_s3_item;
        end
    end

    // division: Q_W stages, one quotient bit each; quotient ends up in .low
    t_div_item w_div [Q_W+1];
    assign w_div[0] = r_s3_item;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        mwm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_item  (w_div[g]),
            .o_item  (w_div[g+1])
        );
    end

    // square stage
    logic [LANES-1:0][SQ_W-1:0] r_sq;
    logic [LANES-1:0]           r_sq_neg;
    logic                       r_sq_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (w_en) begin
            r_sq_valid <= w_div[Q_W].valid;
            r_sq_neg   <= w_div[Q_W].neg;
            for (int l = 0; l < LANES; l++) begin
                r_sq[l] <= SQ_W'(w_div[Q_W].low[l]) * SQ_W'(w_div[Q_W].low[l]);
            end
        end
    end

    // output register: drop fraction, restore sign, clamp to the port range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_sq_valid;
            for (int l = 0; l < LANES; l++) begin
                r_out[l] <= sat_out(r_sq_neg[l], r_sq[l][SQ_W-1:FRACTION_BITS]);
            end
        end
    end

    assign o_wheels.valid             = r_out_valid;
    assign o_wheels.front_left_drive  = r_out[LANE_FL];
    assign o_wheels.front_right_drive = r_out[LANE_FR];
    assign o_wheels.rear_left_drive   = r_out[LANE_RL];
    assign o_wheels.rear_right_drive  = r_out[LANE_RR];

endmodule
